// ===== rtl/rcs_pkg.sv =====
// Package: shared types and constants for the RGB contrast stretch block.
package rcs_pkg;

  localparam int CHAN_W    = 8;
  localparam int DIV_STEPS = 8;
  localparam int CNT_W     = 3;

  // Item commands
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  // Statistic reset values and output ceiling
  localparam logic [CHAN_W-1:0] MIN_RST = 8'hFF;
  localparam logic [CHAN_W-1:0] MAX_RST = 8'h00;
  localparam logic [CHAN_W-1:0] PIX_MAX = 8'hFF;

  typedef logic [CHAN_W-1:0] chan_t;

  // Controller to datapath commands
  typedef struct packed {
    logic stats_upd;
    logic div_load;
    logic div_step;
    logic out_load;
  } rcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } rcs_sts_t;

endpackage

// ===== rtl/rcs_if.sv =====
// Interfaces: pixel input channel and stretched pixel output channel.
interface rcs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       first_of_frame;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output cmd, output first_of_frame,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input cmd, input first_of_frame,
                  input red, input green, input blue, output ready);
endinterface

interface rcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output out_red, output out_green,
                  output out_blue, input ready);
  modport sink   (input valid, input out_red, input out_green,
                  input out_blue, output ready);
endinterface

// ===== rtl/rgb_contrast_stretch.sv =====
// Top level: per-channel min-max contrast stretch of RGB pixels.
//
// Usage: pixels arrive on in_ch with a command bit. A measure item (cmd 0)
// folds the pixel into per-channel running minimum and maximum, restarting
// them when first_of_frame is set, and gives no result. An apply item
// (cmd 1) gives one result item on out_ch: each channel is
// floor((v - min) * 255 / (max - min)), clamped to 0..255, with an empty or
// flat range taken as one.
// Flow: a measure item is taken every cycle while no apply item is in
// progress. An apply item runs a bit-serial restoring divide in each channel
// lane, one quotient bit a cycle, and in_ch is not ready for the next item
// until its result has been loaded into the output register.
// A finished result sits in an output register; the next item may be
// accepted while it waits. If the receiver stalls, a following apply item
// holds after its last step until the register is free, and in_ch is not
// ready meanwhile. Reset (rst_n low, synchronous) sets the minima to 255,
// the maxima to 0 and empties the output register.
module rgb_contrast_stretch
  import rcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rcs_in_if.sink    in_ch,
  rcs_out_if.source out_ch
);

  rcs_cmd_t cmd;
  rcs_sts_t sts;

  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .first_of_frame (in_ch.first_of_frame),
    .red            (in_ch.red),
    .green          (in_ch.green),
    .blue           (in_ch.blue),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_red        (out_ch.out_red),
    .out_green      (out_ch.out_green),
    .out_blue       (out_ch.out_blue)
  );

endmodule

// ===== rtl/rcs_div_lane.sv =====
// One channel's stretch lane: offset, range and bit-serial restoring divide.
module rcs_div_lane
  import rcs_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  logic  step,
  input  chan_t pix,
  input  chan_t lo,
  input  chan_t hi,
  output chan_t result
);

  logic [CHAN_W:0]     range_s;
  logic [CHAN_W:0]     diff_s;
  chan_t               den;
  chan_t               diff;
  logic                sat;
  logic [2*CHAN_W-1:0] num;
  logic [CHAN_W:0]     shifted;
  logic [CHAN_W:0]     trial;
  logic                ge;

  chan_t rem_r, rem_nxt;
  chan_t quo_r, quo_nxt;
  chan_t den_r;
  logic  neg_r;
  logic  sat_r;

  // Range (flat or empty taken as one) and offset from the minimum
  always_comb begin
    range_s = {1'b0, hi} - {1'b0, lo};
    diff_s  = {1'b0, pix} - {1'b0, lo};
    diff    = diff_s[CHAN_W-1:0];
    if (range_s[CHAN_W] || (range_s == '0)) begin
      den = chan_t'(1);
    end else begin
      den = range_s[CHAN_W-1:0];
    end
    // offset at or above range always saturates to full scale
    sat = !diff_s[CHAN_W] && (diff >= den);
    // diff * 255 as a shift and subtract
    num = {diff, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, diff};
  end

  // One quotient bit per step; high half of the numerator is below den
  always_comb begin
    shifted = {rem_r, quo_r[CHAN_W-1]};
    trial   = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? trial[CHAN_W-1:0] : shifted[CHAN_W-1:0];
    quo_nxt = {quo_r[CHAN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= num[2*CHAN_W-1:CHAN_W];
      quo_r <= num[CHAN_W-1:0];
      den_r <= den;
      neg_r <= diff_s[CHAN_W];
      sat_r <= sat;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Clamp: below minimum gives zero, saturated gives full scale
  always_comb begin
    if (neg_r) begin
      result = '0;
    end else if (sat_r) begin
      result = PIX_MAX;
    end else begin
      result = quo_r;
    end
  end

endmodule

// ===== rtl/rcs_datapath.sv =====
// Datapath: per-channel min/max statistics, three divide lanes, output register.
module rcs_datapath
  import rcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rcs_cmd_t cmd,
  output rcs_sts_t sts,
  input  logic     first_of_frame,
  input  chan_t    red,
  input  chan_t    green,
  input  chan_t    blue,
  output logic     out_valid,
  input  logic     out_ready,
  output chan_t    out_red,
  output chan_t    out_green,
  output chan_t    out_blue
);

  chan_t pix [3];
  chan_t lo_r [3];
  chan_t hi_r [3];
  chan_t res [3];
  chan_t res_r [3];
  logic  out_valid_r;

  assign pix[0] = red;
  assign pix[1] = green;
  assign pix[2] = blue;

  // Running statistics; restart on the first measured pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= MIN_RST;
        hi_r[i] <= MAX_RST;
      end
    end else if (cmd.stats_upd) begin
      for (int i = 0; i < 3; i++) begin
        if (first_of_frame || (pix[i] < lo_r[i])) lo_r[i] <= pix[i];
        if (first_of_frame || (pix[i] > hi_r[i])) hi_r[i] <= pix[i];
      end
    end
  end

  // Divide lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    rcs_div_lane u_lane (
      .clk    (clk),
      .load   (cmd.div_load),
      .step   (cmd.div_step),
      .pix    (pix[g]),
      .lo     (lo_r[g]),
      .hi     (hi_r[g]),
      .result (res[g])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < 3; i++) res_r[i] <= res[i];
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_red      = res_r[0];
  assign out_green    = res_r[1];
  assign out_blue     = res_r[2];

endmodule

// ===== rtl/rcs_ctrl.sv =====
// Controller: item acceptance and sequencing of the divide steps.
module rcs_ctrl
  import rcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  rcs_sts_t sts,
  output rcs_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_APPLY) begin
            cmd.div_load = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end else begin
            cmd.stats_upd = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
